@@ design/mpd_pkg.sv @@
// ----------------------------------------------------------------------------
// mpd_pkg
// Shared types and constants for the packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package mpd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CKSUM_W   = 16;
    localparam int unsigned TDATA_W   = 64;
    localparam int unsigned TUSER_W   = 4;
    localparam int unsigned PAD_W     = TDATA_W - (5 * BYTE_W + 1 + CKSUM_W);

    // length byte plus descriptor byte
    localparam logic [BYTE_W-1:0] FIELD_HEADER = 8'd2;

    localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'd117;
    localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'd101;

    // configuration register indexes
    localparam logic CFG_FIRST_SYNC  = 1'b0;
    localparam logic CFG_SECOND_SYNC = 1'b1;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ROLE_LENGTH = 2'd0,
        ROLE_DESC   = 2'd1,
        ROLE_DATA   = 2'd2
    } t_role;

    typedef struct packed {
        logic [BYTE_W-1:0] first_sync;
        logic [BYTE_W-1:0] second_sync;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  descriptor_set;
        logic [BYTE_W-1:0]  payload_byte;
        logic [BYTE_W-1:0]  byte_index;
        logic [BYTE_W-1:0]  field_descriptor;
        t_role              field_role;
        logic [BYTE_W-1:0]  field_offset;
        logic               field_malformed;
        logic [CKSUM_W-1:0] received_checksum;
        logic               last;
    } t_result;

endpackage

`default_nettype wire

@@ design/mpd_parser.sv @@
// ----------------------------------------------------------------------------
// mpd_parser
// Per-byte frame state machine: sync hunt, header, field tagging of payload
// bytes, Fletcher-8 accumulation and checksum verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_parser (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic [7:0]              i_byte,
    input  wire mpd_pkg::t_cfg           i_cfg,
    output logic                         o_res_valid,
    output mpd_pkg::t_result             o_res
);
    import mpd_pkg::*;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_SYNC2,
        ST_SET,
        ST_LEN,
        ST_PAYLOAD,
        ST_CKH,
        ST_CKL
    } t_state;

    t_state              r_state, n_state;
    logic [BYTE_W-1:0]   r_set, n_set;
    logic [BYTE_W-1:0]   r_plen, n_plen;
    logic [BYTE_W-1:0]   r_pcnt, n_pcnt;
    logic [BYTE_W-1:0]   r_sum1, n_sum1;
    logic [BYTE_W-1:0]   r_sum2, n_sum2;
    logic [BYTE_W-1:0]   r_ckh, n_ckh;
    logic [BYTE_W-1:0]   r_fpos, n_fpos;
    logic [BYTE_W-1:0]   r_flen, n_flen;
    logic [BYTE_W-1:0]   r_fdesc, n_fdesc;

    logic [BYTE_W-1:0]   w_flen;
    logic [BYTE_W-1:0]   w_start;
    logic [BYTE_W:0]     w_fend;
    logic [BYTE_W:0]     w_fpos_inc;
    logic [BYTE_W-1:0]   w_sum1_acc;
    logic [BYTE_W-1:0]   w_sum1_new;
    logic [CKSUM_W-1:0]  w_rx;

    // running pair continued, and restarted on a fresh first sync byte
    assign w_sum1_acc = r_sum1 + i_byte;
    assign w_sum1_new = i_byte;

    // field length in force for this byte: a length byte sets it
    assign w_flen     = (r_fpos == '0) ? i_byte : r_flen;
    assign w_start    = r_pcnt - r_fpos;
    assign w_fend     = {1'b0, w_start} + {1'b0, w_flen};
    assign w_fpos_inc = {1'b0, r_fpos} + {{BYTE_W{1'b0}}, 1'b1};
    assign w_rx       = {r_ckh, i_byte};

    always_comb begin
        n_state = r_state;
        n_set   = r_set;
        n_plen  = r_plen;
        n_pcnt  = r_pcnt;
        n_sum1  = r_sum1;
        n_sum2  = r_sum2;
        n_ckh   = r_ckh;
        n_fpos  = r_fpos;
        n_flen  = r_flen;
        n_fdesc = r_fdesc;

        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.descriptor_set = r_set;

        unique case (r_state)
            ST_HUNT: begin
                if (i_byte == i_cfg.first_sync) begin
                    n_sum1  = w_sum1_new;
                    n_sum2  = w_sum1_new;
                    n_state = ST_SYNC2;
                end
            end
            ST_SYNC2: begin
                if (i_byte == i_cfg.second_sync) begin
                    n_sum1  = w_sum1_acc;
                    n_sum2  = r_sum2 + w_sum1_acc;
                    n_state = ST_SET;
                end else if (i_byte == i_cfg.first_sync) begin
                    n_sum1  = w_sum1_new;
                    n_sum2  = w_sum1_new;
                end else begin
                    n_state = ST_HUNT;
                end
            end
            ST_SET: begin
                n_set   = i_byte;
                n_sum1  = w_sum1_acc;
                n_sum2  = r_sum2 + w_sum1_acc;
                n_state = ST_LEN;
            end
            ST_LEN: begin
                n_plen  = i_byte;
                n_pcnt  = '0;
                n_fpos  = '0;
                n_flen  = '0;
                n_fdesc = '0;
                n_sum1  = w_sum1_acc;
                n_sum2  = r_sum2 + w_sum1_acc;
                n_state = (i_byte == '0) ? ST_CKH : ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                n_sum1  = w_sum1_acc;
                n_sum2  = r_sum2 + w_sum1_acc;
                o_res_valid          = 1'b1;
                o_res.kind           = KIND_PAYLOAD;
                o_res.payload_byte   = i_byte;
                o_res.byte_index     = r_pcnt;
                priority if (r_fpos == '0) begin
                    n_flen = i_byte;
                    o_res.field_role = ROLE_LENGTH;
                end else if (r_fpos == 8'd1) begin
                    n_fdesc = i_byte;
                    o_res.field_role       = ROLE_DESC;
                    o_res.field_descriptor = i_byte;
                end else begin
                    o_res.field_role       = ROLE_DATA;
                    o_res.field_descriptor = r_fdesc;
                    o_res.field_offset     = r_fpos - FIELD_HEADER;
                end
                o_res.field_malformed = (w_flen < FIELD_HEADER) ||
                                        (w_fend > {1'b0, r_plen});
                // a short field closes after its descriptor byte
                if ((r_fpos != '0) && (w_fpos_inc >= {1'b0, w_flen})) begin
                    n_fpos = '0;
                end else begin
                    n_fpos = w_fpos_inc[BYTE_W-1:0];
                end
                n_pcnt = r_pcnt + 8'd1;
                if (n_pcnt >= r_plen) begin
                    n_state = ST_CKH;
                end
            end
            ST_CKH: begin
                n_ckh   = i_byte;
                n_state = ST_CKL;
            end
            ST_CKL: begin
                o_res_valid             = 1'b1;
                o_res.kind              = (w_rx == {r_sum1, r_sum2}) ? KIND_GOOD : KIND_BAD;
                o_res.received_checksum = w_rx;
                o_res.last              = 1'b1;
                n_state                 = ST_HUNT;
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_set   <= n_set;
            r_plen  <= n_plen;
            r_pcnt  <= n_pcnt;
            r_sum1  <= n_sum1;
            r_sum2  <= n_sum2;
            r_ckh   <= n_ckh;
            r_fpos  <= n_fpos;
            r_flen  <= n_flen;
            r_fdesc <= n_fdesc;
        end
    end

endmodule

`default_nettype wire

@@ design/mpd_out_stage.sv @@
// ----------------------------------------------------------------------------
// mpd_out_stage
// Result register toward the output stream; loads whenever empty or drained.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_out_stage (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire mpd_pkg::t_result        i_res,
    input  wire logic                    i_ready,
    output logic                         o_load,
    output logic                         o_valid,
    output mpd_pkg::t_result             o_res
);
    import mpd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_load  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

@@ design/mip_packet_deframer_core.sv @@
// ----------------------------------------------------------------------------
// mip_packet_deframer_core
// Packet deframer with Fletcher-8 check and cut-through payload tagging.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle at full rate while the output is not
// stalled. Each byte lands in an input register, is decoded combinationally
// by the frame state machine, and its result (if any) lands in an output
// register. Sync and header bytes give no beat; each payload byte gives a
// tagged beat, and the second checksum byte gives the verdict beat with tlast
// set. Output backpressure stalls the decode stage; the input register keeps
// taking bytes while the output register is free or draining. Sync values are
// to be written by the user via the config port while idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_packet_deframer_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config write port
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_addr,
    input  wire logic [mpd_pkg::BYTE_W-1:0]    i_cfg_wdata,
    // input stream; tdata: data_byte
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [mpd_pkg::BYTE_W-1:0]    i_s_axis_tdata,
    // output stream
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // tdata: descriptor_set[7:0], payload_byte[15:8], byte_index[23:16],
    //        field_descriptor[31:24], field_offset[39:32], field_malformed[40],
    //        received_checksum[56:41], zero pad[63:57]
    output logic [mpd_pkg::TDATA_W-1:0]        o_m_axis_tdata,
    // tuser: kind[1:0], field_role[3:2]
    output logic [mpd_pkg::TUSER_W-1:0]        o_m_axis_tuser,
    output logic                               o_m_axis_tlast
);
    import mpd_pkg::*;

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              w_load;
    logic              w_en;
    logic              w_res_valid;
    t_result           w_res;
    t_result           w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_sync  <= FIRST_SYNC_RST;
            r_cfg.second_sync <= SECOND_SYNC_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FIRST_SYNC:  r_cfg.first_sync  <= i_cfg_wdata;
                CFG_SECOND_SYNC: r_cfg.second_sync <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = !r_in_valid || w_load;
    assign w_en            = r_in_valid && w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    mpd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_byte      (r_in_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    mpd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_en && w_res_valid),
        .i_res   (w_res),
        .i_ready (i_m_axis_tready),
        .o_load  (w_load),
        .o_valid (o_m_axis_tvalid),
        .o_res   (w_out)
    );

    assign o_m_axis_tdata = {{PAD_W{1'b0}},
                             w_out.received_checksum,
                             w_out.field_malformed,
                             w_out.field_offset,
                             w_out.field_descriptor,
                             w_out.byte_index,
                             w_out.payload_byte,
                             w_out.descriptor_set};
    assign o_m_axis_tuser = {w_out.field_role, w_out.kind};
    assign o_m_axis_tlast = w_out.last;

    // verdict beat is never tagged as payload
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (w_out.kind != KIND_PAYLOAD))
        else $error("verdict beat carries payload kind");

    // beats without tlast are payload beats and carry no checksum
    a_payload_cksum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |->
            ((w_out.received_checksum == '0) && (w_out.kind == KIND_PAYLOAD)))
        else $error("payload beat with checksum or verdict kind");

    // a byte waiting on a stalled output stays in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_load) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input register lost a byte under stall");

    // only data bytes have a nonzero field offset
    a_offset_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (w_out.field_role != ROLE_DATA)) |->
            (w_out.field_offset == '0))
        else $error("field offset on header byte");

endmodule

`default_nettype wire

@@ tb/mip_packet_deframer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_packet_deframer_core_tb
// Self-checking regression for the packet deframer core.
// ----------------------------------------------------------------------------
// Drives raw stream bytes: short directed frames (empty payload, bad checksum,
// short and overrunning fields, sync recovery), frames under extreme sync
// settings, a long random mix of good frames, corrupted frames and line noise,
// and a long output stall. A byte-level frame decoder predicts every output
// beat, and each beat taken is compared field by field with the oldest one.
// ----------------------------------------------------------------------------

module mip_packet_deframer_core_tb;
    import mpd_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_BYTES  = 300;
    localparam int IDLE_PCT      = 21;
    localparam int TIMEOUT_NS    = 2_000_000;

    typedef logic [7:0] t_byte;

    typedef enum logic [2:0] {
        HUNT, SYNC2, SET_BYTE, LEN_BYTE, BODY, CK_HI, CK_LO
    } t_frame_phase;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic                  i_cfg_addr;
    logic [BYTE_W-1:0]     i_cfg_wdata;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [BYTE_W-1:0]     i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [TDATA_W-1:0]    o_m_axis_tdata;
    logic [TUSER_W-1:0]    o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    mip_packet_deframer_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // predictor copy of the configuration and frame state
    t_byte        sync_a;
    t_byte        sync_b;
    t_frame_phase rx_phase;
    t_byte        frame_set;
    t_byte        body_len;
    t_byte        body_cnt;
    t_byte        fl_sum1;
    t_byte        fl_sum2;
    t_byte        ck_hi;
    t_byte        fld_pos;
    t_byte        fld_len;
    t_byte        fld_desc;

    t_result      expected_beats[$];
    t_byte        body_q[$];
    int           fail_count;
    bit           tx_idle_on;
    bit           rx_idle_on;
    int           hold_requests;
    int           hold_served;
    int           hold_left;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // queue helpers
    // ------------------------------------------------------------------
    task automatic expect_beat(input t_result r);
        expected_beats.insert(expected_beats.size(), r);
    endtask

    task automatic body_append(input t_byte b);
        body_q.insert(body_q.size(), b);
    endtask

    // ------------------------------------------------------------------
    // frame decoder model
    // ------------------------------------------------------------------
    task automatic frame_reset;
        sync_a   = FIRST_SYNC_RST;
        sync_b   = SECOND_SYNC_RST;
        rx_phase = HUNT;
        frame_set = '0;
        body_len = '0;
        body_cnt = '0;
        fl_sum1  = '0;
        fl_sum2  = '0;
        ck_hi    = '0;
        fld_pos  = '0;
        fld_len  = '0;
        fld_desc = '0;
    endtask

    task automatic fletcher_add(input t_byte b);
        fl_sum1 = fl_sum1 + b;
        fl_sum2 = fl_sum2 + fl_sum1;
    endtask

    task automatic frame_predict(input t_byte b);
        t_result r;
        int      start;
        r = '0;
        case (rx_phase)
            HUNT: begin
                if (b == sync_a) begin
                    fl_sum1  = b;
                    fl_sum2  = b;
                    rx_phase = SYNC2;
                end
            end
            SYNC2: begin
                if (b == sync_b) begin
                    fletcher_add(b);
                    rx_phase = SET_BYTE;
                end else if (b == sync_a) begin
                    // a repeated first sync restarts the frame
                    fl_sum1 = b;
                    fl_sum2 = b;
                end else begin
                    rx_phase = HUNT;
                end
            end
            SET_BYTE: begin
                frame_set = b;
                fletcher_add(b);
                rx_phase = LEN_BYTE;
            end
            LEN_BYTE: begin
                body_len = b;
                body_cnt = '0;
                fld_pos  = '0;
                fld_len  = '0;
                fld_desc = '0;
                fletcher_add(b);
                rx_phase = (b == 8'd0) ? CK_HI : BODY;
            end
            BODY: begin
                fletcher_add(b);
                r.kind           = KIND_PAYLOAD;
                r.descriptor_set = frame_set;
                r.payload_byte   = b;
                r.byte_index     = body_cnt;
                if (fld_pos == 8'd0) begin
                    fld_len      = b;
                    r.field_role = ROLE_LENGTH;
                end else if (fld_pos == 8'd1) begin
                    fld_desc           = b;
                    r.field_role       = ROLE_DESC;
                    r.field_descriptor = b;
                end else begin
                    r.field_role       = ROLE_DATA;
                    r.field_descriptor = fld_desc;
                    r.field_offset     = fld_pos - 8'd2;
                end
                start = int'(body_cnt) - int'(fld_pos);
                r.field_malformed = (int'(fld_len) < 2) ||
                                    (start + int'(fld_len) > int'(body_len));
                expect_beat(r);
                // short fields end after the descriptor byte
                if (fld_pos >= 8'd1 && int'(fld_pos) + 1 >= int'(fld_len))
                    fld_pos = '0;
                else
                    fld_pos = fld_pos + 8'd1;
                body_cnt = body_cnt + 8'd1;
                if (body_cnt >= body_len)
                    rx_phase = CK_HI;
            end
            CK_HI: begin
                ck_hi    = b;
                rx_phase = CK_LO;
            end
            CK_LO: begin
                r.kind = ({ck_hi, b} == {fl_sum1, fl_sum2}) ? KIND_GOOD : KIND_BAD;
                r.descriptor_set    = frame_set;
                r.received_checksum = {ck_hi, b};
                r.last              = 1'b1;
                expect_beat(r);
                rx_phase = HUNT;
            end
            default: rx_phase = HUNT;
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // returns right after the beat is taken; the caller lowers tvalid when done
    task automatic push_byte(input t_byte b);
        @(negedge i_clk);
        if (tx_idle_on) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        frame_predict(b);
    endtask

    task automatic wait_quiet;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input t_byte v);
        wait_quiet();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FIRST_SYNC)
            sync_a = v;
        else
            sync_b = v;
    endtask

    function automatic logic [15:0] frame_fletcher(input t_byte set_b);
        t_byte s1;
        t_byte s2;
        t_byte x;
        s1 = '0;
        s2 = '0;
        for (int k = 0; k < body_q.size() + 4; k++) begin
            case (k)
                0:       x = sync_a;
                1:       x = sync_b;
                2:       x = set_b;
                3:       x = t_byte'(body_q.size());
                default: x = body_q[k-4];
            endcase
            s1 = s1 + x;
            s2 = s2 + s1;
        end
        return {s1, s2};
    endfunction

    // field list with mostly well-formed fields, some short and some overrunning
    task automatic make_body(input int len);
        int rem;
        int flen;
        int r;
        body_q.delete();
        while (body_q.size() < len) begin
            rem = len - body_q.size();
            r   = $urandom_range(0, 99);
            if (r < 8)
                flen = $urandom_range(0, 1);
            else if (r < 14 && rem < 250)
                flen = $urandom_range(rem + 1, rem + 5);
            else
                flen = $urandom_range(2, (rem < 2) ? 2 : ((rem > 12) ? 12 : rem));
            body_append(t_byte'(flen));
            if (body_q.size() < len)
                body_append(t_byte'($urandom));
            for (int j = 2; j < flen && body_q.size() < len; j++)
                body_append(t_byte'($urandom));
        end
    endtask

    function automatic int pick_len;
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return $urandom_range(200, 255);
        if (r < 15)
            return 0;
        return $urandom_range(1, 24);
    endfunction

    // ck_xor of zero gives a good checksum
    task automatic send_frame(input t_byte set_b, input logic [15:0] ck_xor);
        logic [15:0] ck;
        ck = frame_fletcher(set_b) ^ ck_xor;
        push_byte(sync_a);
        push_byte(sync_b);
        push_byte(set_b);
        push_byte(t_byte'(body_q.size()));
        foreach (body_q[i]) push_byte(body_q[i]);
        push_byte(ck[15:8]);
        push_byte(ck[7:0]);
    endtask

    task automatic send_random_frames(input int count);
        t_byte set_b;
        repeat (count) begin
            set_b = t_byte'($urandom);
            make_body(pick_len());
            send_frame(set_b, ($urandom_range(0, 3) == 0) ? 16'h0001 : 16'h0000);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_frames;
        localparam logic [79:0] FIELD_MIX = {
            8'h01, 8'hFF,             // length one
            8'h00, 8'h00,             // length zero
            8'h03, 8'h10, 8'hFF,      // well formed, one data byte
            8'h05, 8'h20, 8'h00       // runs past the payload end
        };
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        // wrong second sync, then a repeated first sync
        push_byte(sync_a);
        push_byte(8'h00);
        push_byte(sync_a);
        body_q.delete();
        send_frame(8'h00, 16'h0000);
        // empty payload, bad checksum of all ones
        send_frame(8'hFF, frame_fletcher(8'hFF) ^ 16'hFFFF);
        body_q.delete();
        for (int i = 0; i < 10; i++)
            body_append(FIELD_MIX[79 - 8*i -: 8]);
        send_frame(8'h80, 16'h0000);
        wait_quiet();
    endtask

    task automatic test_sync_settings;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        write_reg(CFG_FIRST_SYNC, 8'h00);
        write_reg(CFG_SECOND_SYNC, 8'hFF);
        push_byte(8'h00);
        push_byte(8'h01);
        send_random_frames(4);
        write_reg(CFG_FIRST_SYNC, 8'hFF);
        write_reg(CFG_SECOND_SYNC, 8'h00);
        send_random_frames(4);
        // equal sync values: the second sync match wins
        write_reg(CFG_FIRST_SYNC, 8'h5A);
        write_reg(CFG_SECOND_SYNC, 8'h5A);
        send_random_frames(4);
        write_reg(CFG_FIRST_SYNC, FIRST_SYNC_RST);
        write_reg(CFG_SECOND_SYNC, SECOND_SYNC_RST);
    endtask

    task automatic test_random_traffic;
        int          sent;
        int          r;
        bit          quiet_stretch;
        t_byte       set_b;
        logic [15:0] ck_err;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            // middle third runs without any idling
            quiet_stretch = (sent * 3 / RANDOM_BYTES) == 1;
            tx_idle_on = !quiet_stretch;
            rx_idle_on = !quiet_stretch;
            r = $urandom_range(0, 99);
            if (r < 80) begin
                set_b  = t_byte'($urandom);
                ck_err = (r < 68) ? 16'h0000 : 16'($urandom_range(1, 65535));
                make_body(pick_len());
                send_frame(set_b, ck_err);
                sent += body_q.size() + 6;
            end else if (r < 90) begin
                repeat ($urandom_range(1, 4)) push_byte(t_byte'($urandom));
            end else begin
                push_byte(sync_a);
                push_byte(t_byte'($urandom));
            end
        end
        wait_quiet();
    endtask

    task automatic test_backpressure;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_requests++;
        make_body(200);
        send_frame(t_byte'($urandom), 16'h0000);
        wait_quiet();
    endtask

    // ------------------------------------------------------------------
    // output side: ready pattern and beat checking
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (rx_idle_on) begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_beats
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_beats.size() == 0) begin
                $error("output beat with no result expected");
                fail_count++;
            end else begin
                want = expected_beats.pop_front();
                check_field("kind", want.kind, o_m_axis_tuser[1:0]);
                check_field("field_role", want.field_role, o_m_axis_tuser[3:2]);
                check_field("descriptor_set", want.descriptor_set, o_m_axis_tdata[7:0]);
                check_field("payload_byte", want.payload_byte, o_m_axis_tdata[15:8]);
                check_field("byte_index", want.byte_index, o_m_axis_tdata[23:16]);
                check_field("field_descriptor", want.field_descriptor,
                            o_m_axis_tdata[31:24]);
                check_field("field_offset", want.field_offset, o_m_axis_tdata[39:32]);
                check_field("field_malformed", want.field_malformed, o_m_axis_tdata[40]);
                check_field("received_checksum", want.received_checksum,
                            o_m_axis_tdata[56:41]);
                check_field("tdata_pad", 0, o_m_axis_tdata[63:57]);
                check_field("last", want.last, o_m_axis_tlast);
            end
        end
    end

    // ------------------------------------------------------------------
    // run control
    // ------------------------------------------------------------------
    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = CFG_FIRST_SYNC;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        fail_count      = 0;
        tx_idle_on      = 1'b0;
        rx_idle_on      = 1'b0;
        hold_requests   = 0;
        hold_served     = 0;
        hold_left       = 0;
        frame_reset();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_sync_settings();
        test_random_traffic();
        test_backpressure();

        wait_quiet();
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("mip_packet_deframer_core regression: pass");
        else
            $display("mip_packet_deframer_core regression: fail");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("mip_packet_deframer_core regression: fail");
        $finish;
    end

endmodule
